/* rtl/hsmas_pkg.sv */
// Shared types, base codes and widths for the hotspot motif alignment scorer.
package hsmas_pkg;

  localparam int SCORE_BITS  = 16;
  localparam int OUT_BITS    = 16;
  localparam int BASE_BITS   = 3;
  localparam int WEIGHT_BITS = 4;
  localparam int ADD_BITS    = WEIGHT_BITS + 2;
  localparam int INDEX_BITS  = 3;
  localparam int WINDOW_LEN  = 4;

  typedef logic [BASE_BITS-1:0] base_t;

  localparam base_t BASE_A     = 3'd0;
  localparam base_t BASE_C     = 3'd1;
  localparam base_t BASE_G     = 3'd2;
  localparam base_t BASE_T     = 3'd3;
  localparam base_t BASE_OTHER = 3'd4;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_MATCH = 3'd0,
    REG_WRCY  = 3'd1,
    REG_RGYW  = 3'd2,
    REG_WAN   = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] match_w;
    logic [WEIGHT_BITS-1:0] wrcy_w;
    logic [WEIGHT_BITS-1:0] rgyw_w;
    logic [WEIGHT_BITS-1:0] wan_w;
  } weights_t;

  typedef struct packed {
    logic  is_match;
    base_t ref_base;
    logic  last_pos;
  } item_t;

endpackage

/* rtl/hotspot_motif_alignment_scorer_unit.sv */
// Top level of the hotspot motif alignment scorer: input register, core and result register.
//
// Usage: a profile is sent one position per request on the input channel
// (in_valid, in_stall, is_match, ref_base, last_pos), starting at position 0.
// The request with last_pos set closes the profile; it yields exactly one
// request on the output channel (out_valid, out_stall, profile_score) and
// clears the profile state. Other positions yield nothing.
// Weights are written through cfg_we, cfg_index and cfg_data while idle;
// indexes 0 to 3 select match, WRCY, RGYW and WAN weights, others are ignored.
// Throughput: one position per cycle while in_stall is low. Every position
// passes the input register and then the motif logic and saturating add;
// the score of a closing position is then captured in the result register.
// A stalled result is held in the result register; positions keep flowing
// until the next closing position reaches the core, which then waits in the
// input register and raises in_stall until the result is taken.
// Reset clears the profile state, the pipeline valids and sets the weights
// to 1, 3, 3 and 2.
module hotspot_motif_alignment_scorer_unit
  import hsmas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   is_match,
  input  logic [BASE_BITS-1:0]   ref_base,
  input  logic                   last_pos,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_BITS-1:0]    profile_score,
  input  logic                   cfg_we,
  input  logic [INDEX_BITS-1:0]  cfg_index,
  input  logic [WEIGHT_BITS-1:0] cfg_data
);

  weights_t             weights;
  logic                 s1_valid;
  item_t                s1_item;
  logic                 step;
  logic                 accept_in;
  logic [OUT_BITS-1:0]  final_score;

  hsmas_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .weights   (weights)
  );

  hsmas_score_core u_score_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (s1_item),
    .weights     (weights),
    .final_score (final_score)
  );

  assign step      = s1_valid && (!s1_item.last_pos || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !step;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_item.is_match <= is_match;
      s1_item.ref_base <= ref_base;
      s1_item.last_pos <= last_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s1_item.last_pos) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_item.last_pos) begin
      profile_score <= final_score;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_item.last_pos && out_valid)
    else $error("input stalled without a blocked closing position");

  a_close_gives_result: assert property (@(posedge clk) disable iff (rst)
    step && s1_item.last_pos |=> out_valid)
    else $error("closing position did not produce a result");

  a_result_from_close: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step && s1_item.last_pos))
    else $error("result appeared without a closing position");

endmodule

/* rtl/hsmas_cfg_regs.sv */
// Weight registers written through the configuration port.
module hsmas_cfg_regs
  import hsmas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [INDEX_BITS-1:0]  cfg_index,
  input  logic [WEIGHT_BITS-1:0] cfg_data,
  output weights_t               weights
);

  always_ff @(posedge clk) begin
    if (rst) begin
      weights.match_w <= WEIGHT_BITS'(1);
      weights.wrcy_w  <= WEIGHT_BITS'(3);
      weights.rgyw_w  <= WEIGHT_BITS'(3);
      weights.wan_w   <= WEIGHT_BITS'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH: weights.match_w <= cfg_data;
        REG_WRCY:  weights.wrcy_w  <= cfg_data;
        REG_RGYW:  weights.rgyw_w  <= cfg_data;
        REG_WAN:   weights.wan_w   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/hsmas_motif_dec.sv */
// Motif window checks and the score increment for one position.
module hsmas_motif_dec
  import hsmas_pkg::*;
(
  input  base_t                 window [WINDOW_LEN],
  input  logic                  pend_prev2,
  input  logic                  pend_prev1,
  input  item_t                 item,
  input  weights_t              weights,
  output logic [ADD_BITS-1:0]   add_amt
);

  function automatic logic is_w(base_t b);
    return (b == BASE_A) || (b == BASE_T);
  endfunction

  function automatic logic is_r(base_t b);
    return (b == BASE_A) || (b == BASE_G);
  endfunction

  function automatic logic is_y(base_t b);
    return (b == BASE_C) || (b == BASE_T);
  endfunction

  logic                 wrcy_a;
  logic                 rgyw_b;
  logic                 wan_b;
  logic                 wrcy_tail;
  logic [ADD_BITS-1:0]  settle_amt;
  logic [ADD_BITS-1:0]  match_amt;
  logic [ADD_BITS-1:0]  tail_amt;

  assign wrcy_a = is_w(window[0]) && is_r(window[1]) && (window[2] == BASE_C) &&
                  is_y(window[3]);
  assign rgyw_b = is_r(window[1]) && (window[2] == BASE_G) && is_y(window[3]) &&
                  is_w(item.ref_base);
  assign wan_b  = is_w(window[1]) && (window[2] == BASE_A);

  // The pending mismatch one position back sees only its first window at the end.
  assign wrcy_tail = is_w(window[1]) && is_r(window[2]) && (window[3] == BASE_C) &&
                     is_y(item.ref_base);

  always_comb begin
    settle_amt = '0;
    if (pend_prev2) begin
      if (wrcy_a) begin
        settle_amt = ADD_BITS'(weights.wrcy_w);
      end else if (rgyw_b) begin
        settle_amt = ADD_BITS'(weights.rgyw_w);
      end else if (wan_b) begin
        settle_amt = ADD_BITS'(weights.wan_w);
      end
    end
  end

  assign match_amt = item.is_match ? ADD_BITS'(weights.match_w) : '0;
  assign tail_amt  = (item.last_pos && pend_prev1 && wrcy_tail) ?
                     ADD_BITS'(weights.wrcy_w) : '0;
  assign add_amt   = settle_amt + match_amt + tail_amt;

endmodule

/* rtl/hsmas_score_core.sv */
// Base window, pending mismatch flags, position count and saturating accumulator.
module hsmas_score_core
  import hsmas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  item_t                item,
  input  weights_t             weights,
  output logic [OUT_BITS-1:0]  final_score
);

  localparam int EXT_BITS = SCORE_BITS + OUT_BITS;
  localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

  base_t                  window [WINDOW_LEN];
  logic                   pend_prev2;
  logic                   pend_prev1;
  logic [1:0]             position_count;
  logic [SCORE_BITS-1:0]  score_acc;

  logic [ADD_BITS-1:0]    add_amt;
  logic [SCORE_BITS:0]    sum;
  logic [SCORE_BITS-1:0]  score_next;
  logic [EXT_BITS-1:0]    score_ext;
  logic                   mism_here;

  hsmas_motif_dec u_motif_dec (
    .window     (window),
    .pend_prev2 (pend_prev2),
    .pend_prev1 (pend_prev1),
    .item       (item),
    .weights    (weights),
    .add_amt    (add_amt)
  );

  assign sum        = {1'b0, score_acc} + (SCORE_BITS + 1)'(add_amt);
  assign score_next = sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];
  assign score_ext  = {{OUT_BITS{1'b0}}, score_next};
  assign final_score = (score_ext > EXT_BITS'(OUT_MAX)) ? OUT_MAX :
                       score_ext[OUT_BITS-1:0];
  assign mism_here  = !item.is_match && (position_count >= 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= BASE_OTHER;
      end
      pend_prev2     <= 1'b0;
      pend_prev1     <= 1'b0;
      position_count <= '0;
      score_acc      <= '0;
    end else if (step) begin
      if (item.last_pos) begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
          window[i] <= BASE_OTHER;
        end
        pend_prev2     <= 1'b0;
        pend_prev1     <= 1'b0;
        position_count <= '0;
        score_acc      <= '0;
      end else begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          window[i] <= window[i+1];
        end
        window[WINDOW_LEN-1] <= item.ref_base;
        pend_prev2 <= pend_prev1;
        pend_prev1 <= mism_here;
        if (position_count != 2'd3) begin
          position_count <= position_count + 2'd1;
        end
        score_acc <= score_next;
      end
    end
  end

endmodule

/* verif/hotspot_motif_alignment_scorer_unit_tb.sv */
// Self-checking testbench for the hotspot motif alignment scorer with a built-in score predictor.
`timescale 1ns / 1ps

module hotspot_motif_alignment_scorer_unit_tb;
  import hsmas_pkg::*;

  localparam int IDLE_PCT      = 26;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 10;
  localparam int PHASES        = 6;
  localparam int CALM_PHASE    = 2;
  localparam int PHASE_ITEMS   = 275;
  localparam int MAX_LEN       = 48;
  localparam int PLAN_LEN      = 22;

  localparam base_t BASE_JUNK = 3'd7;
  localparam logic [OUT_BITS-1:0] SCORE_CAP = '1;

  typedef enum int {HIT_WRCY, HIT_RGYW, HIT_WAN} motif_t;

  typedef struct packed {
    logic                is_match;
    base_t               ref_base;
    logic                last_pos;
    logic                typed;
    logic [OUT_BITS-1:0] score;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{1'b1, BASE_A,     1'b1, 1'b1, 16'd1},
    '{1'b0, BASE_OTHER, 1'b1, 1'b1, 16'd0},
    '{1'b1, BASE_T,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_A,     1'b0, 1'b0, 16'd0},
    '{1'b0, BASE_C,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_T,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_G,     1'b1, 1'b0, 16'd0},
    '{1'b1, BASE_C,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_A,     1'b0, 1'b0, 16'd0},
    '{1'b0, BASE_G,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_C,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_T,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_JUNK,  1'b1, 1'b0, 16'd0},
    '{1'b1, BASE_G,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_T,     1'b0, 1'b0, 16'd0},
    '{1'b0, BASE_A,     1'b0, 1'b0, 16'd0},
    '{1'b0, BASE_G,     1'b0, 1'b0, 16'd0},
    '{1'b0, BASE_C,     1'b1, 1'b0, 16'd0},
    '{1'b1, BASE_A,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_G,     1'b0, 1'b0, 16'd0},
    '{1'b0, BASE_C,     1'b0, 1'b0, 16'd0},
    '{1'b1, BASE_C,     1'b1, 1'b0, 16'd0}
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   is_match = 1'b0;
  logic [BASE_BITS-1:0]   ref_base = BASE_OTHER;
  logic                   last_pos = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [OUT_BITS-1:0]    profile_score;
  logic                   cfg_we = 1'b0;
  logic [INDEX_BITS-1:0]  cfg_index = '0;
  logic [WEIGHT_BITS-1:0] cfg_data = '0;

  logic [OUT_BITS-1:0] owed_scores [$];
  logic [OUT_BITS-1:0] owed;
  int                  bad_scores = 0;
  bit                  calm = 1'b0;

  weights_t        weights;
  base_t           recent [WINDOW_LEN];
  bit              miss_prev;
  bit              miss_cur;
  int unsigned     positions_seen;
  longint unsigned running_score;

  hotspot_motif_alignment_scorer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .is_match(is_match), .ref_base(ref_base), .last_pos(last_pos),
    .out_valid(out_valid), .out_stall(out_stall), .profile_score(profile_score),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit is_weak(base_t b);
    return b == BASE_A || b == BASE_T;
  endfunction

  function automatic bit is_purine(base_t b);
    return b == BASE_A || b == BASE_G;
  endfunction

  function automatic bit is_pyrimidine(base_t b);
    return b == BASE_C || b == BASE_T;
  endfunction

  function automatic bit wrcy_window(base_t a, base_t b, base_t c, base_t d);
    return is_weak(a) && is_purine(b) && c == BASE_C && is_pyrimidine(d);
  endfunction

  function automatic base_t any_base();
    if ($urandom_range(0, 9) < 8) return base_t'($urandom_range(BASE_A, BASE_T));
    return base_t'($urandom_range(BASE_OTHER, BASE_JUNK));
  endfunction

  function automatic base_t weak_base();
    return $urandom_range(0, 1) ? BASE_T : BASE_A;
  endfunction

  function automatic base_t purine_base();
    return $urandom_range(0, 1) ? BASE_G : BASE_A;
  endfunction

  function automatic base_t pyrimidine_base();
    return $urandom_range(0, 1) ? BASE_T : BASE_C;
  endfunction

  task automatic clear_profile();
    foreach (recent[i]) recent[i] = BASE_OTHER;
    miss_prev = 1'b0;
    miss_cur = 1'b0;
    positions_seen = 0;
    running_score = 0;
  endtask

  task automatic add_weight(input logic [WEIGHT_BITS-1:0] w);
    longint unsigned cap;
    cap = (longint'(1) << SCORE_BITS) - 1;
    running_score = (running_score + w > cap) ? cap : running_score + w;
  endtask

  task automatic score_position(input bit m, input base_t b, input bit l,
                                output bit closed, output logic [OUT_BITS-1:0] total);
    bit fresh_miss;
    if (miss_prev) begin
      if (wrcy_window(recent[0], recent[1], recent[2], recent[3]))
        add_weight(weights.wrcy_w);
      else if (is_purine(recent[1]) && recent[2] == BASE_G && is_pyrimidine(recent[3]) &&
               is_weak(b))
        add_weight(weights.rgyw_w);
      else if (is_weak(recent[1]) && recent[2] == BASE_A)
        add_weight(weights.wan_w);
    end
    if (m) add_weight(weights.match_w);
    fresh_miss = !m && positions_seen >= 2;
    miss_prev = miss_cur;
    miss_cur = fresh_miss;
    recent[0] = recent[1];
    recent[1] = recent[2];
    recent[2] = recent[3];
    recent[3] = b;
    if (positions_seen < 3) positions_seen++;
    closed = l;
    total = '0;
    if (l) begin
      if (miss_prev && wrcy_window(recent[0], recent[1], recent[2], recent[3]))
        add_weight(weights.wrcy_w);
      total = (running_score > SCORE_CAP) ? SCORE_CAP : running_score[OUT_BITS-1:0];
      clear_profile();
    end
  endtask

  task automatic send_position(input bit m, input base_t b, input bit l,
                               input bit typed, input logic [OUT_BITS-1:0] typed_score);
    bit closed;
    logic [OUT_BITS-1:0] total;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    is_match <= m;
    ref_base <= b;
    last_pos <= l;
    do @(posedge clk); while (in_stall);
    score_position(m, b, l, closed, total);
    if (closed) owed_scores = {owed_scores, (typed ? typed_score : total)};
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (owed_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_weights(input weights_t w);
    for (int k = 0; k < 2 ** INDEX_BITS; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= k[INDEX_BITS-1:0];
      case (reg_idx_t'(k))
        REG_MATCH: cfg_data <= w.match_w;
        REG_WRCY:  cfg_data <= w.wrcy_w;
        REG_RGYW:  cfg_data <= w.rgyw_w;
        REG_WAN:   cfg_data <= w.wan_w;
        default:   cfg_data <= WEIGHT_BITS'($urandom_range(0, 15));
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    weights = w;
  endtask

  task automatic run_profile(inout int sent);
    base_t pb [MAX_LEN];
    bit    pm [MAX_LEN];
    int    len;
    int    j;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_LEN) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      pb[i] = any_base();
      pm[i] = 1'($urandom_range(0, 1));
    end
    if (len >= 3 && $urandom_range(0, 9) < 8) begin
      repeat ($urandom_range(1, 3)) begin
        j = $urandom_range(2, len - 1);
        case (motif_t'($urandom_range(HIT_WRCY, HIT_WAN)))
          HIT_WRCY: begin
            pb[j-2] = weak_base();
            pb[j-1] = purine_base();
            pb[j] = BASE_C;
            if (j + 1 < len) pb[j+1] = pyrimidine_base();
          end
          HIT_RGYW: begin
            pb[j-1] = purine_base();
            pb[j] = BASE_G;
            if (j + 1 < len) pb[j+1] = pyrimidine_base();
            if (j + 2 < len) pb[j+2] = weak_base();
          end
          default: begin
            pb[j-1] = weak_base();
            pb[j] = BASE_A;
          end
        endcase
        pm[j] = 1'b0;
      end
    end
    for (int i = 0; i < len; i++) send_position(pm[i], pb[i], i == len - 1, 1'b0, '0);
    sent += len;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (owed_scores.size() == 0) begin
        $display("%0t: profile_score expected none got %0d", $time, profile_score);
        bad_scores++;
      end else begin
        owed = owed_scores.pop_front();
        if (profile_score !== owed) begin
          $display("%0t: profile_score expected %0d got %0d", $time, owed, profile_score);
          bad_scores++;
        end
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    weights_t w;
    int       sent;
    weights = '{match_w: 4'd1, wrcy_w: 4'd3, rgyw_w: 4'd3, wan_w: 4'd2};
    clear_profile();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i])
      send_position(PLAN[i].is_match, PLAN[i].ref_base, PLAN[i].last_pos,
                    PLAN[i].typed, PLAN[i].score);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       w = '{match_w: 4'd0, wrcy_w: 4'd0, rgyw_w: 4'd0, wan_w: 4'd0};
        1:       w = '{match_w: 4'd15, wrcy_w: 4'd15, rgyw_w: 4'd15, wan_w: 4'd15};
        2:       w = '{match_w: 4'd0, wrcy_w: 4'd15, rgyw_w: 4'd9, wan_w: 4'd4};
        default: w = weights_t'($urandom);
      endcase
      settle();
      program_weights(w);
      calm = (ph == CALM_PHASE);
      sent = 0;
      while (sent < PHASE_ITEMS) run_profile(sent);
    end

    in_valid <= 1'b0;
    while (owed_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_scores == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
